>>> hdl/gfba_pkg.sv
// Package for the grouped free-block allocator.
// Holds the word types of both channels, status codes and the controller/datapath bundles.
// No dependencies.
package gfba_pkg;

  localparam int ID_W     = 10;
  localparam int STATUS_W = 2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic            opcode;
    logic [ID_W-1:0] block_id;
  } in_word_t;

  typedef struct packed {
    logic [ID_W-1:0]     alloc_block;
    logic [STATUS_W-1:0] status;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic push;
    logic pop;
    logic set_range;
    logic set_empty;
    logic spill_step;
    logic spill_done;
    logic reload_step;
    logic reload_done;
    logic emit;
  } cmd_t;

  // Conditions reported by the datapath.
  typedef struct packed {
    logic is_free;
    logic id_bad;
    logic stack_empty;
    logic stack_full;
    logic leader_end;
    logic slot_last;
  } stat_t;

endpackage

>>> hdl/gfba_dp.sv
// Datapath of the grouped free-block allocator: cached stack, count, leader link,
// group store, link store, result and output registers. Depends on gfba_pkg.
module gfba_dp #(
  parameter int TOTAL_BLOCKS = 1024,
  parameter int GROUP_SIZE   = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gfba_pkg::in_word_t in_data,
  input  gfba_pkg::cmd_t     cmd,
  output gfba_pkg::stat_t    stat,
  output gfba_pkg::out_word_t out_data
);

  localparam int SD        = GROUP_SIZE - 1;
  localparam int SLOT_W    = (SD > 1) ? $clog2(SD) : 1;
  localparam int CNT_W     = $clog2(SD + 1);
  localparam int BID_W     = $clog2(TOTAL_BLOCKS);
  localparam int LINK_W    = $clog2(TOTAL_BLOCKS + 1);
  localparam int MEM_DEPTH = TOTAL_BLOCKS << SLOT_W;

  logic [gfba_pkg::ID_W-1:0]     stack_mem [SD];
  logic [gfba_pkg::ID_W-1:0]     grp_mem   [MEM_DEPTH];
  logic [LINK_W-1:0]             link_mem  [TOTAL_BLOCKS];

  logic [CNT_W-1:0]              count_r;
  logic [LINK_W-1:0]             leader_r;
  logic [SLOT_W-1:0]             slot_r;
  logic                          fill_en_r;
  logic [SLOT_W-1:0]             fill_slot_r;
  logic [gfba_pkg::ID_W-1:0]     grp_rd_r;
  logic [LINK_W-1:0]             link_rd_r;
  logic                          lat_op_r;
  logic [gfba_pkg::ID_W-1:0]     lat_id_r;
  logic [gfba_pkg::ID_W-1:0]     res_block_r;
  logic [gfba_pkg::STATUS_W-1:0] res_status_r;
  gfba_pkg::out_word_t           out_r;

  logic [BID_W-1:0]              id_idx;
  logic [BID_W-1:0]              leader_idx;
  logic [BID_W-1:0]              grp_blk;
  logic [SLOT_W-1:0]             stack_rd_idx;
  logic [gfba_pkg::ID_W-1:0]     stack_rd;

  assign id_idx       = BID_W'(lat_id_r);
  assign leader_idx   = BID_W'(leader_r);
  assign grp_blk      = cmd.spill_step ? id_idx : leader_idx;
  assign stack_rd_idx = cmd.spill_step ? slot_r : SLOT_W'(count_r - 1'b1);
  assign stack_rd     = stack_mem[stack_rd_idx];

  assign stat.is_free     = (lat_op_r == gfba_pkg::OP_FREE);
  assign stat.id_bad      = (32'(lat_id_r) >= TOTAL_BLOCKS);
  assign stat.stack_empty = (count_r == '0);
  assign stat.stack_full  = (32'(count_r) >= SD);
  assign stat.leader_end  = (32'(leader_r) >= TOTAL_BLOCKS);
  assign stat.slot_last   = (slot_r == SLOT_W'(SD - 1));

  assign out_data = out_r;

  // Control-relevant state: count, leader and the slot sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      leader_r  <= LINK_W'(TOTAL_BLOCKS);
      slot_r    <= '0;
      fill_en_r <= 1'b0;
    end else begin
      fill_en_r <= cmd.reload_step;
      if (cmd.latch) begin
        slot_r <= '0;
      end else if (cmd.spill_step || cmd.reload_step) begin
        slot_r <= slot_r + 1'b1;
      end
      if (cmd.push) begin
        count_r <= count_r + 1'b1;
      end else if (cmd.pop) begin
        count_r <= count_r - 1'b1;
      end else if (cmd.spill_done) begin
        count_r  <= '0;
        leader_r <= LINK_W'(lat_id_r);
      end else if (cmd.reload_done) begin
        count_r  <= CNT_W'(SD);
        leader_r <= link_rd_r;
      end
    end
  end

  // Cached stack: one write per cycle from a push or a reload fill.
  always_ff @(posedge clk) begin
    fill_slot_r <= slot_r;
    if (cmd.push) begin
      stack_mem[SLOT_W'(count_r)] <= lat_id_r;
    end else if (fill_en_r) begin
      stack_mem[fill_slot_r] <= grp_rd_r;
    end
  end

  // Group store, one port: spill writes, reload reads with registered data.
  always_ff @(posedge clk) begin
    if (cmd.spill_step) begin
      grp_mem[{grp_blk, slot_r}] <= stack_rd;
    end
    grp_rd_r <= grp_mem[{grp_blk, slot_r}];
  end

  always_ff @(posedge clk) begin
    if (cmd.spill_done) begin
      link_mem[id_idx] <= leader_r;
    end
    link_rd_r <= link_mem[leader_idx];
  end

  // Latched request, pending result and output word.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      lat_op_r <= in_data.opcode;
      lat_id_r <= in_data.block_id;
    end
    if (cmd.pop) begin
      res_block_r  <= stack_rd;
      res_status_r <= gfba_pkg::ST_OK;
    end else if (cmd.reload_done) begin
      res_block_r  <= gfba_pkg::ID_W'(leader_r);
      res_status_r <= gfba_pkg::ST_OK;
    end else if (cmd.push || cmd.spill_done) begin
      res_block_r  <= '0;
      res_status_r <= gfba_pkg::ST_OK;
    end else if (cmd.set_range) begin
      res_block_r  <= '0;
      res_status_r <= gfba_pkg::ST_RANGE;
    end else if (cmd.set_empty) begin
      res_block_r  <= '0;
      res_status_r <= gfba_pkg::ST_EMPTY;
    end
    if (cmd.emit) begin
      out_r.alloc_block <= res_block_r;
      out_r.status      <= res_status_r;
    end
  end

endmodule

>>> hdl/gfba_ctrl.sv
// Controller of the grouped free-block allocator: request sequencing and output valid.
// Depends on gfba_pkg.
module gfba_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  gfba_pkg::stat_t stat,
  output gfba_pkg::cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE       = 6'b000001,
    S_DECIDE     = 6'b000010,
    S_SPILL      = 6'b000100,
    S_RELOAD     = 6'b001000,
    S_RELOAD_END = 6'b010000,
    S_DONE       = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_DONE;
        if (stat.is_free) begin
          if (stat.id_bad) begin
            cmd.set_range = 1'b1;
          end else if (stat.stack_full) begin
            state_nxt = S_SPILL;
          end else begin
            cmd.push = 1'b1;
          end
        end else if (!stat.stack_empty) begin
          cmd.pop = 1'b1;
        end else if (stat.leader_end) begin
          cmd.set_empty = 1'b1;
        end else begin
          state_nxt = S_RELOAD;
        end
      end
      S_SPILL: begin
        cmd.spill_step = 1'b1;
        if (stat.slot_last) begin
          cmd.spill_done = 1'b1;
          state_nxt      = S_DONE;
        end
      end
      S_RELOAD: begin
        cmd.reload_step = 1'b1;
        if (stat.slot_last) begin
          state_nxt = S_RELOAD_END;
        end
      end
      S_RELOAD_END: begin
        cmd.reload_done = 1'b1;
        state_nxt       = S_DONE;
      end
      S_DONE: begin
        // The result waits here only while the output register still holds an unread word.
        if (!out_valid_r || out_ready) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> hdl/grouped_free_block_allocator.sv
// Top level of the grouped free-block allocator.
// Depends on gfba_pkg, gfba_ctrl and gfba_dp.
//
//   Channel   Direction  Word         Handshake
//   in_       input      in_word_t    in_valid / in_ready
//   out_      output     out_word_t   out_valid / out_ready
//
// A word is taken only while the controller is idle; a plain push, pop or failure passes
// through S_DECIDE and S_DONE before its result reaches the output register.
// A spill onto a full stack passes through S_SPILL, and a reload from the group store through
// S_RELOAD and S_RELOAD_END: the single-port group store moves one stack entry per cycle.
// Reset (rst_n low, synchronous) empties the stack and sets the leader link to the end marker.
// The next word is accepted while a result waits in the output register; only a second
// result stalls behind an untaken one.
module grouped_free_block_allocator #(
  parameter int TOTAL_BLOCKS = 1024,
  parameter int GROUP_SIZE   = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gfba_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output gfba_pkg::out_word_t out_data
);

  gfba_pkg::cmd_t  cmd;
  gfba_pkg::stat_t stat;

  gfba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  gfba_dp #(
    .TOTAL_BLOCKS (TOTAL_BLOCKS),
    .GROUP_SIZE   (GROUP_SIZE)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule
